>>> rtl/core/bcec_pkg.sv
// shared types and codes for the button chord event classifier
`default_nettype none

package bcec_pkg;

	localparam int unsigned CODE_W  = 8;
	localparam int unsigned TICKS_W = 16;
	localparam int unsigned NSLOTS  = 3;

	// item kinds
	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;

	// event codes
	localparam logic [2:0] EV_SHORT     = 3'd0;
	localparam logic [2:0] EV_LONG      = 3'd1;
	localparam logic [2:0] EV_TWO_SHORT = 3'd2;
	localparam logic [2:0] EV_TWO_LONG  = 3'd3;
	localparam logic [2:0] EV_ERROR     = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_NO_BUTTON  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS = 2'd1;

	localparam logic [CODE_W-1:0]  NO_BUTTON_RESET  = 8'd255;
	localparam logic [TICKS_W-1:0] LONG_TICKS_RESET = 16'd1000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CODE_W-1:0] button;
	} item_t;

	typedef struct packed {
		logic [2:0]        event_code;
		logic [CODE_W-1:0] first_button;
		logic [CODE_W-1:0] second_button;
	} result_t;

	typedef struct packed {
		logic [1:0]         held_count;
		logic [CODE_W-1:0]  code2;
		logic [CODE_W-1:0]  code1;
		logic [CODE_W-1:0]  code0;
		logic               multiple_flag;
		logic               double_flag;
		logic               long_flag;
		logic               timer_running;
		logic [TICKS_W-1:0] tick_count;
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/bcec_step.sv
// next-state and event logic for one item
`default_nettype none

module bcec_step import bcec_pkg::*; (
	input  wire item_t              item,
	input  wire state_t             cur,
	input  wire logic [CODE_W-1:0]  no_button,
	input  wire logic [TICKS_W-1:0] long_ticks,
	output state_t                  nxt,
	output logic                    has_event,
	output result_t                 result
);

	logic [CODE_W-1:0]  codes [NSLOTS];
	logic [CODE_W-1:0]  ncodes [NSLOTS];
	logic [NSLOTS-1:0]  match;
	logic [NSLOTS-1:0]  hit;
	logic               found;
	logic [1:0]         hit_idx;
	logic [1:0]         last_idx;
	logic [TICKS_W:0]   next_tick;

	always_comb begin
		codes[0] = cur.code0;
		codes[1] = cur.code1;
		codes[2] = cur.code2;
		last_idx = cur.held_count - 2'd1;
		next_tick = {1'b0, cur.tick_count} + {{TICKS_W{1'b0}}, 1'b1};

		// first held slot holding the released code
		for (int i = 0; i < NSLOTS; i++) begin
			match[i] = (2'(i) < cur.held_count) && (codes[i] == item.button);
		end
		hit[0] = match[0];
		hit[1] = match[1] & ~match[0];
		hit[2] = match[2] & ~match[1] & ~match[0];
		found = |hit;
		hit_idx = hit[2] ? 2'd2 : (hit[1] ? 2'd1 : 2'd0);

		for (int j = 0; j < NSLOTS; j++) begin
			ncodes[j] = codes[j];
		end

		nxt = cur;
		has_event = 1'b0;
		result.event_code = EV_SHORT;
		result.first_button = no_button;
		result.second_button = no_button;

		case (item.kind)
			KIND_PRESS: begin
				if (cur.held_count < 2'd2) begin
					ncodes[cur.held_count] = item.button;
					nxt.double_flag = (cur.held_count == 2'd1);
					nxt.held_count = cur.held_count + 2'd1;
					nxt.multiple_flag = 1'b0;
					nxt.long_flag = 1'b0;
					nxt.tick_count = '0;
					nxt.timer_running = 1'b1;
				end else if (cur.held_count == 2'd2) begin
					nxt.timer_running = 1'b0;
					has_event = 1'b1;
					result.event_code = EV_ERROR;
					ncodes[2] = item.button;
					nxt.held_count = 2'd3;
					nxt.multiple_flag = 1'b1;
					nxt.double_flag = 1'b0;
					nxt.long_flag = 1'b0;
				end else begin
					nxt.multiple_flag = 1'b1;
				end
			end
			KIND_RELEASE: begin
				nxt.timer_running = 1'b0;
				if (cur.held_count != 2'd0) begin
					if (!cur.long_flag && !cur.multiple_flag) begin
						has_event = 1'b1;
						if (cur.double_flag) begin
							nxt.multiple_flag = 1'b1;
							result.event_code = EV_TWO_SHORT;
							result.first_button = codes[0];
							result.second_button = codes[1];
						end else begin
							result.event_code = EV_SHORT;
							result.first_button = codes[last_idx];
						end
					end
					if (found) begin
						// shift later slots down over the removed one
						for (int j = 0; j < NSLOTS - 1; j++) begin
							if (2'(j) >= hit_idx && 2'(j) < last_idx) begin
								ncodes[j] = codes[j+1];
							end
						end
						ncodes[last_idx] = no_button;
						nxt.held_count = last_idx;
					end
				end
			end
			KIND_TICK: begin
				if (cur.timer_running) begin
					if (next_tick >= {1'b0, long_ticks}) begin
						nxt.tick_count = '0;
						nxt.long_flag = 1'b1;
						if (!cur.multiple_flag && !cur.double_flag) begin
							has_event = 1'b1;
							result.event_code = EV_LONG;
							result.first_button = codes[0];
						end else if (cur.double_flag) begin
							has_event = 1'b1;
							result.event_code = EV_TWO_LONG;
							result.first_button = codes[0];
							result.second_button = codes[1];
						end
					end else begin
						nxt.tick_count = next_tick[TICKS_W-1:0];
					end
				end
			end
			default: begin
				// unused kind: no change
			end
		endcase

		nxt.code0 = ncodes[0];
		nxt.code1 = ncodes[1];
		nxt.code2 = ncodes[2];
	end

endmodule

`default_nettype wire

>>> rtl/core/bcec_out_buf.sv
// result register with skid stage
`default_nettype none

module bcec_out_buf import bcec_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         space,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    main_vld_q;
	logic    skid_vld_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop = main_vld_q && out_ready;
	assign space = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_vld_q || pop) begin
				main_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (pop) begin
			main_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_vld_q || pop) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid word held with empty result register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push)
		else $error("word pushed into full result buffer");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && pop) |=> (main_vld_q && main_q == $past(skid_q)))
		else $error("skid word lost on drain");

endmodule

`default_nettype wire

>>> rtl/core/button_chord_event_classifier_core.sv
// top level of the button chord event classifier
//
// usage
//   in channel  : in_valid/in_ready with in_data (kind, button); one word is a
//                 press, a release or a timer tick
//   out channel : out_valid/out_ready with out_data (event_code, first_button,
//                 second_button); a word only appears for items that raise an event
//   cfg channel : cfg_valid/cfg_ready with cfg_index/cfg_data; index 0 sets the
//                 no-button code, index 1 the long-press period; always ready,
//                 other indexes are dropped
//   registering : an event word is registered in the result register (skid if full)
//   throughput  : one item every cycle while in_ready is high; the state update is
//                 one pass of logic from held-button registers to result register
//   stalling    : a two-word buffer (result register plus skid word) sits on the
//                 output; in_ready drops only while both are full, so one waiting
//                 result never holds up the next item
//   reset       : arst_n clears the held list to code 255, all flags, the tick
//                 counter and the buffer; registers return to 255 and 1000
`default_nettype none

module button_chord_event_classifier_core import bcec_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire item_t                  in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output result_t                     out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [TICKS_W-1:0]     cfg_data
);

	// configuration registers
	logic [CODE_W-1:0]  no_button_q;
	logic [TICKS_W-1:0] long_ticks_q;

	// held-button state
	state_t  state_q;
	state_t  state_nxt;
	logic    has_event;
	result_t result;
	logic    accept;
	logic    space;

	assign cfg_ready = 1'b1;
	assign in_ready = space;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_button_q <= NO_BUTTON_RESET;
			long_ticks_q <= LONG_TICKS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NO_BUTTON:  no_button_q <= cfg_data[CODE_W-1:0];
				CFG_LONG_TICKS: long_ticks_q <= cfg_data;
				default: begin
					// unmapped index
				end
			endcase
		end
	end

	// state update for one item per cycle while in_ready is high
	bcec_step u_step (
		.item       (in_data),
		.cur        (state_q),
		.no_button  (no_button_q),
		.long_ticks (long_ticks_q),
		.nxt        (state_nxt),
		.has_event  (has_event),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.held_count <= 2'd0;
			state_q.code0 <= NO_BUTTON_RESET;
			state_q.code1 <= NO_BUTTON_RESET;
			state_q.code2 <= NO_BUTTON_RESET;
			state_q.multiple_flag <= 1'b0;
			state_q.double_flag <= 1'b0;
			state_q.long_flag <= 1'b0;
			state_q.timer_running <= 1'b0;
			state_q.tick_count <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result register and skid word
	bcec_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && has_event),
		.push_data (result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// the timer only runs with one or two buttons down
	a_timer_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.timer_running |-> (state_q.held_count == 2'd1 || state_q.held_count == 2'd2))
		else $error("timer running with no single or double hold");

	// three held buttons always mean a multiple press
	a_three_is_multiple: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.held_count == 2'd3) |-> state_q.multiple_flag)
		else $error("three buttons held without multiple flag");

	// a tick with the timer stopped leaves the state alone
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.kind == KIND_TICK && !state_q.timer_running)
		|=> ($stable(state_q) && !$past(has_event)))
		else $error("stopped timer changed on tick");

endmodule

`default_nettype wire
